// ===== rtl/core/dd_pkg.sv =====
`timescale 1ns / 1ps

package dd_pkg;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int STAT_W  = 2;
    localparam int R400_W  = 9;

    // Calendar limits
    localparam logic [YEAR_W-1:0]  MAX_YEAR    = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  CYCLE_YEARS = YEAR_W'(400);
    localparam logic [R400_W-1:0]  LAST_R400   = R400_W'(399);
    localparam logic [MONTH_W-1:0] LAST_MONTH  = MONTH_W'(12);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BEFORE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
    } t_dd_in;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic [STAT_W-1:0]  status;
    } t_dd_out;

    // Leap year from the year modulo 400: divisible by 4, not a century
    // unless the century is a multiple of 400.
    function automatic logic f_is_leap(input logic [R400_W-1:0] r400);
        logic century;
        century = (r400 == R400_W'(100)) || (r400 == R400_W'(200))
               || (r400 == R400_W'(300));
        return (r400[1:0] == 2'b00) && !century;
    endfunction

    // Length of a month; zero for a month code outside the calendar.
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/dd_mod400.sv =====
`timescale 1ns / 1ps

module dd_mod400 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dd_pkg::YEAR_W-1:0] i_year,
    output logic                      o_done,
    output logic [dd_pkg::R400_W-1:0] o_rem
);
    import dd_pkg::*;

    logic              r_busy;
    logic [YEAR_W-1:0] r_rem;
    logic              w_below;

    assign w_below = (r_rem < CYCLE_YEARS);
    assign o_done  = r_busy && w_below;
    assign o_rem   = r_rem[R400_W-1:0];

    // Subtract 400 once per cycle until the remainder drops below 400
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_below) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_year;
        end else if (r_busy && !w_below) begin
            r_rem <= r_rem - CYCLE_YEARS;
        end
    end

endmodule

// ===== rtl/core/date_difference_in_days.sv =====
`timescale 1ns / 1ps

// Counts the days from a start date to an end date in the Gregorian calendar.
// One transaction is taken at a time: the block first reduces the start year
// and then the end year modulo 400 by repeated subtraction in a shared unit,
// checks both dates, then walks a running date forward one day per cycle until
// it meets the end date. A date with a bad month, bad day or year above 9999
// returns status 2 and a count of 0; an end date before the start returns
// status 1 and a count of 0. The result register lets a new transaction be
// accepted while the previous result still waits on the output.
module date_difference_in_days (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dd_pkg::t_dd_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dd_pkg::t_dd_out o_out_data
);
    import dd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_S,
        S_MOD_E,
        S_CHECK,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;

    // Latched request
    t_dd_in r_req;

    // Year residues modulo 400
    logic [R400_W-1:0] r_s_r400;
    logic [R400_W-1:0] r_e_r400;

    // Running date and day counter
    logic [DAY_W-1:0]   r_walk_day;
    logic [MONTH_W-1:0] r_walk_month;
    logic [YEAR_W-1:0]  r_walk_year;
    logic [R400_W-1:0]  r_walk_r400;
    logic [COUNT_W-1:0] r_days_counted;

    // Pending result and output register
    t_dd_out r_res;
    logic    r_out_valid;
    t_dd_out r_out_data;

    // Shared modulo unit
    logic              w_mod_start;
    logic [YEAR_W-1:0] w_mod_year;
    logic              w_mod_done;
    logic [R400_W-1:0] w_mod_rem;

    logic w_in_fire;
    logic w_out_free;

    // Date checks
    logic [DAY_W-1:0] w_s_len;
    logic [DAY_W-1:0] w_e_len;
    logic             w_s_ok;
    logic             w_e_ok;
    logic             w_before;
    logic [DAY_W-1:0] w_walk_len;
    logic             w_at_end;

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Feed the modulo unit the start year on accept, the end year after it
    assign w_mod_start = w_in_fire || ((r_state == S_MOD_S) && w_mod_done);
    assign w_mod_year  = (r_state == S_IDLE) ? i_in_data.start_year : r_req.end_year;

    dd_mod400 u_mod400 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_year  (w_mod_year),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // Validate both dates and order them
    assign w_s_len = f_month_len(r_req.start_month, f_is_leap(r_s_r400));
    assign w_e_len = f_month_len(r_req.end_month, f_is_leap(r_e_r400));
    assign w_s_ok  = (r_req.start_year <= MAX_YEAR) && (w_s_len != '0)
                  && (r_req.start_day != '0) && (r_req.start_day <= w_s_len);
    assign w_e_ok  = (r_req.end_year <= MAX_YEAR) && (w_e_len != '0)
                  && (r_req.end_day != '0) && (r_req.end_day <= w_e_len);
    assign w_before = {r_req.end_year, r_req.end_month, r_req.end_day}
                    < {r_req.start_year, r_req.start_month, r_req.start_day};

    // Running date against the end date
    assign w_walk_len = f_month_len(r_walk_month, f_is_leap(r_walk_r400));
    assign w_at_end   = (r_walk_day == r_req.end_day) && (r_walk_month == r_req.end_month)
                     && (r_walk_year == r_req.end_year);

    // Sequencer: state, running date and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_walk_day     <= DAY_W'(1);
            r_walk_month   <= MONTH_W'(1);
            r_walk_year    <= '0;
            r_walk_r400    <= '0;
            r_days_counted <= '0;
        end else begin
            // Present a finished result, or drop the one that completes
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_state <= S_MOD_S;
                    end
                end
                S_MOD_S: begin
                    if (w_mod_done) begin
                        r_state <= S_MOD_E;
                    end
                end
                S_MOD_E: begin
                    if (w_mod_done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_s_ok || !w_e_ok) begin
                        r_state <= S_DONE;
                    end else if (w_before) begin
                        r_state <= S_DONE;
                    end else begin
                        r_walk_day     <= r_req.start_day;
                        r_walk_month   <= r_req.start_month;
                        r_walk_year    <= r_req.start_year;
                        r_walk_r400    <= r_s_r400;
                        r_days_counted <= '0;
                        r_state        <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_at_end) begin
                        r_state <= S_DONE;
                    end else begin
                        // Advance one day, rolling month and year over
                        if (r_walk_day < w_walk_len) begin
                            r_walk_day <= r_walk_day + DAY_W'(1);
                        end else begin
                            r_walk_day <= DAY_W'(1);
                            if (r_walk_month < LAST_MONTH) begin
                                r_walk_month <= r_walk_month + MONTH_W'(1);
                            end else begin
                                r_walk_month <= MONTH_W'(1);
                                r_walk_year  <= r_walk_year + YEAR_W'(1);
                                r_walk_r400  <= (r_walk_r400 == LAST_R400) ? '0
                                              : r_walk_r400 + R400_W'(1);
                            end
                        end
                        if (r_days_counted != COUNT_MAX) begin
                            r_days_counted <= r_days_counted + COUNT_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req <= i_in_data;
        end
        if ((r_state == S_MOD_S) && w_mod_done) begin
            r_s_r400 <= w_mod_rem;
        end
        if ((r_state == S_MOD_E) && w_mod_done) begin
            r_e_r400 <= w_mod_rem;
        end
        if (r_state == S_CHECK) begin
            r_res.day_count <= '0;
            if (!w_s_ok || !w_e_ok) begin
                r_res.status <= ST_INVALID;
            end else if (w_before) begin
                r_res.status <= ST_BEFORE;
            end else begin
                r_res.status <= ST_OK;
            end
        end
        if ((r_state == S_WALK) && w_at_end) begin
            r_res.day_count <= r_days_counted;
            r_res.status    <= ST_OK;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_data <= r_res;
        end
    end

endmodule

// ===== sim/date_difference_in_days_test.sv =====
`timescale 1ns / 1ps

module date_difference_in_days_test;

    import dd_pkg::*;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    in_valid = 1'b0;
    t_dd_in  in_data  = '0;
    logic    out_ready = 1'b0;
    logic    in_ready;
    logic    out_valid;
    t_dd_out out_data;

    t_dd_out     pending_spans[$];
    int          error_count = 0;
    longint      cycle_count = 0;
    longint      cycle_limit = 4000;
    int          burst_left  = 0;
    int          stall_left  = 0;
    int          stall_mode  = 0;

    date_difference_in_days u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Calendar arithmetic for the expected day counts
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
        if (y > MAX_YEAR)
            return 1'b0;
        if (m < 1 || m > 12)
            return 1'b0;
        return (d >= 1) && (d <= month_days(y, m));
    endfunction

    // Days since 1 January of year 0
    function automatic int unsigned day_index(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
        int unsigned n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int unsigned k = 1; k < m; k++)
            n += month_days(y, k);
        return n + d - 1;
    endfunction

    function automatic t_dd_out predict_day_span(input t_dd_in req);
        t_dd_out     res;
        int unsigned first_day;
        int unsigned last_day;
        res.day_count = '0;
        res.status    = ST_OK;
        if (!date_valid(req.start_day, req.start_month, req.start_year)
            || !date_valid(req.end_day, req.end_month, req.end_year)) begin
            res.status = ST_INVALID;
        end else begin
            first_day = day_index(req.start_day, req.start_month, req.start_year);
            last_day  = day_index(req.end_day, req.end_month, req.end_year);
            if (last_day < first_day)
                res.status = ST_BEFORE;
            else if (last_day - first_day > COUNT_MAX)
                res.day_count = COUNT_MAX;
            else
                res.day_count = COUNT_W'(last_day - first_day);
        end
        return res;
    endfunction

    function automatic t_dd_in date_pair(input int unsigned sd, input int unsigned sm,
                                         input int unsigned sy, input int unsigned ed,
                                         input int unsigned em, input int unsigned ey);
        t_dd_in req;
        req.start_day   = DAY_W'(sd);
        req.start_month = MONTH_W'(sm);
        req.start_year  = YEAR_W'(sy);
        req.end_day     = DAY_W'(ed);
        req.end_month   = MONTH_W'(em);
        req.end_year    = YEAR_W'(ey);
        return req;
    endfunction

    // Send one transaction; after a burst of transactions the sender may idle for a random gap
    task automatic send_date_pair(input t_dd_in req);
        t_dd_out expected;
        int      gap;
        expected = predict_day_span(req);
        in_data  <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pending_spans.push_back(expected);
        cycle_limit += 4 * (longint'(expected.day_count) + req.start_year / 400
                            + req.end_year / 400 + 64);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Hold the sender until every outstanding result has been returned
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_spans.size() != 0);
    endtask

    // Receiver: switch between always ready, random and sparse ready
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each returned transaction with the oldest expectation
    always @(posedge clk) begin
        t_dd_out expected;
        if (rst_n && out_valid && out_ready) begin
            if (pending_spans.size() == 0) begin
                $error("unexpected result: day_count %0d status %0d",
                       out_data.day_count, out_data.status);
                error_count++;
            end else begin
                expected = pending_spans.pop_front();
                if (out_data.day_count !== expected.day_count) begin
                    $error("day_count: expected %0d, actual %0d",
                           expected.day_count, out_data.day_count);
                    error_count++;
                end
                if (out_data.status !== expected.status) begin
                    $error("status: expected %0d, actual %0d",
                           expected.status, out_data.status);
                    error_count++;
                end
            end
        end
    end

    // Abort on a hang; the limit grows with each request's walk length
    initial begin
        while (cycle_count < cycle_limit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("date_difference_in_days test failed");
        $finish;
    end

    task automatic check_equal_and_adjacent();
        send_date_pair(date_pair(1, 1, 0, 1, 1, 0));
        send_date_pair(date_pair(31, 12, 9999, 31, 12, 9999));
        send_date_pair(date_pair(31, 12, 1999, 1, 1, 2000));
        send_date_pair(date_pair(30, 4, 2023, 1, 5, 2023));
        send_date_pair(date_pair(1, 1, 0, 1, 1, 1));
    endtask

    task automatic check_leap_rules();
        send_date_pair(date_pair(28, 2, 2000, 1, 3, 2000));
        send_date_pair(date_pair(28, 2, 1900, 1, 3, 1900));
        send_date_pair(date_pair(28, 2, 2004, 1, 3, 2004));
        send_date_pair(date_pair(29, 2, 0, 1, 3, 0));
        send_date_pair(date_pair(1, 1, 2100, 1, 1, 2101));
    endtask

    task automatic check_end_before_start();
        send_date_pair(date_pair(2, 1, 2000, 1, 1, 2000));
        send_date_pair(date_pair(1, 1, 2001, 31, 12, 2000));
        send_date_pair(date_pair(31, 12, 9999, 1, 1, 0));
    endtask

    // Invalid dates win over end-before-start
    task automatic check_invalid_dates();
        send_date_pair(date_pair(1, 0, 2000, 1, 1, 2001));
        send_date_pair(date_pair(1, 1, 2000, 1, 13, 2001));
        send_date_pair(date_pair(15, 15, 2000, 1, 1, 2001));
        send_date_pair(date_pair(0, 1, 2000, 1, 1, 2001));
        send_date_pair(date_pair(31, 4, 2000, 1, 5, 2000));
        send_date_pair(date_pair(29, 2, 1900, 1, 3, 1900));
        send_date_pair(date_pair(1, 1, 2000, 30, 2, 2000));
        send_date_pair(date_pair(1, 1, 9999, 1, 1, 10000));
        send_date_pair(date_pair(1, 1, 16383, 1, 1, 0));
        send_date_pair(date_pair(1, 1, 2000, 0, 1, 1999));
    endtask

    task automatic check_long_span();
        send_date_pair(date_pair(1, 1, 9000, 31, 12, 9999));
    endtask

    function automatic int unsigned pick_year();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(9996, MAX_YEAR);
            2:       return 100 * $urandom_range(0, 99) + $urandom_range(0, 4);
            3:       return 100 * $urandom_range(1, 99) - 1;
            default: return $urandom_range(0, MAX_YEAR);
        endcase
    endfunction

    function automatic void pick_day_month(input int unsigned y, output int unsigned m,
                                           output int unsigned d);
        m = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0)
            d = month_days(y, m);
        else
            d = $urandom_range(1, month_days(y, m));
    endfunction

    function automatic int unsigned bad_day(input int unsigned y, input int unsigned m);
        int unsigned len;
        len = month_days(y, m);
        if (len == 31 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(len + 1, 31);
    endfunction

    function automatic int unsigned bad_month();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        return (pick == 0) ? 0 : 12 + pick;
    endfunction

    // Mostly well-formed short spans, with corrupted fields and raw noise mixed in
    task automatic check_random_requests(input int count);
        int unsigned sd, sm, sy, ed, em, ey, kind;
        logic [63:0] raw;
        t_dd_in      req;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                hold_until_drained();
            kind = $urandom_range(0, 9);
            sy = pick_year();
            pick_day_month(sy, sm, sd);
            ey = sy + $urandom_range(0, 2);
            if (ey > MAX_YEAR)
                ey = MAX_YEAR;
            pick_day_month(ey, em, ed);
            if ($urandom_range(0, 3) == 0 && ey == sy)
                em = sm;
            if (em == sm && ey == sy)
                ed = $urandom_range(1, month_days(ey, em));
            if (kind == 6)
                req = date_pair(ed, em, ey, sd, sm, sy);
            else
                req = date_pair(sd, sm, sy, ed, em, ey);
            if (kind == 7 || kind == 8) begin
                case ($urandom_range(0, 5))
                    0: req.start_day   = DAY_W'(bad_day(sy, sm));
                    1: req.start_month = MONTH_W'(bad_month());
                    2: req.start_year  = YEAR_W'($urandom_range(MAX_YEAR + 1, 16383));
                    3: req.end_day     = DAY_W'(bad_day(ey, em));
                    4: req.end_month   = MONTH_W'(bad_month());
                    default: req.end_year = YEAR_W'($urandom_range(MAX_YEAR + 1, 16383));
                endcase
            end else if (kind == 9) begin
                raw = {$urandom, $urandom};
                req = raw[$bits(t_dd_in)-1:0];
            end
            send_date_pair(req);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_equal_and_adjacent();
        check_leap_rules();
        check_end_before_start();
        check_invalid_dates();
        check_long_span();
        check_random_requests(100);

        // Drain, then give the block time to show any stray transaction
        hold_until_drained();
        repeat (32) @(posedge clk);

        if (error_count == 0)
            $display("date_difference_in_days test passed");
        else
            $display("date_difference_in_days test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dd_pkg.sv
rtl/core/dd_mod400.sv
rtl/core/date_difference_in_days.sv
sim/date_difference_in_days_test.sv
